>>> src/dmmn_pkg.sv
package dmmn_pkg;

	localparam int MAX_WIDTH  = 256;
	localparam int MAX_HEIGHT = 256;
	localparam int STORE_SIZE = MAX_WIDTH * MAX_HEIGHT;
	localparam int ADDR_W     = $clog2(STORE_SIZE);

	localparam int DEPTH_W = 24;
	localparam int GRAY_W  = 16;
	localparam int COORD_W = 8;
	localparam int OP_W    = 2;
	localparam int REG_W   = 3;

	localparam logic [GRAY_W-1:0]  GRAY_ONE  = '1;
	localparam logic [DEPTH_W-1:0] DEPTH_MAX = '1;

	localparam logic [OP_W-1:0] OP_START = 2'd0;
	localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
	localparam logic [OP_W-1:0] OP_READ  = 2'd2;

	localparam logic [REG_W-1:0] REG_AUTO_NORMALISE = 3'd0;
	localparam logic [REG_W-1:0] REG_INVERT_OUTPUT  = 3'd1;
	localparam logic [REG_W-1:0] REG_MANUAL_MIN     = 3'd2;
	localparam logic [REG_W-1:0] REG_MANUAL_MAX     = 3'd3;
	localparam logic [REG_W-1:0] REG_REGION_LEFT    = 3'd4;
	localparam logic [REG_W-1:0] REG_REGION_RIGHT   = 3'd5;
	localparam logic [REG_W-1:0] REG_REGION_BOTTOM  = 3'd6;
	localparam logic [REG_W-1:0] REG_REGION_TOP     = 3'd7;

	typedef struct packed {
		logic [OP_W-1:0]    op;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [DEPTH_W-1:0] depth;
	} item_t;

	typedef struct packed {
		logic [GRAY_W-1:0]  gray;
		logic               processed;
		logic [DEPTH_W-1:0] raw_depth;
	} result_t;

	typedef struct packed {
		logic               start;
		logic [DEPTH_W-1:0] diff;
		logic [DEPTH_W-1:0] span;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [GRAY_W-1:0] quot;
	} div_rsp_t;

endpackage

>>> src/dmmn_ram.sv
module dmmn_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 65536
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> src/dmmn_div.sv
module dmmn_div (
	input  logic               clk,
	input  logic               arst_n,
	input  dmmn_pkg::div_req_t req,
	output dmmn_pkg::div_rsp_t rsp
);

	import dmmn_pkg::*;

	localparam int STEP_W = $clog2(GRAY_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(GRAY_W - 1);

	localparam logic [1:0] D_IDLE = 2'd0;
	localparam logic [1:0] D_PREP = 2'd1;
	localparam logic [1:0] D_RUN  = 2'd2;

	logic [1:0]                state_q;
	logic [STEP_W-1:0]         step_q;
	logic                      done_q;
	logic [DEPTH_W-1:0]        diff_q;
	logic [DEPTH_W-1:0]        span_q;
	logic [DEPTH_W-1:0]        rem_q;
	logic [GRAY_W-1:0]         low_q;
	logic [DEPTH_W+GRAY_W-1:0] num;
	logic [DEPTH_W:0]          trial;
	logic                      fits;

	// numerator = diff * 65535, taken as diff * 2^16 - diff
	assign num   = {diff_q, GRAY_W'(0)} - {GRAY_W'(0), diff_q};
	assign trial = {rem_q, low_q[GRAY_W-1]};
	assign fits  = trial >= {1'b0, span_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= D_IDLE;
			step_q  <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				D_IDLE: begin
					if (req.start) begin
						state_q <= D_PREP;
					end
				end
				D_PREP: begin
					step_q  <= '0;
					state_q <= D_RUN;
				end
				D_RUN: begin
					step_q <= step_q + 1'b1;
					if (step_q == LAST_STEP) begin
						done_q  <= 1'b1;
						state_q <= D_IDLE;
					end
				end
				default: state_q <= D_IDLE;
			endcase
		end
	end

	// Restoring division, one quotient bit a cycle; the quotient shifts into low_q.
	always_ff @(posedge clk) begin
		case (state_q)
			D_IDLE: begin
				if (req.start) begin
					diff_q <= req.diff;
					span_q <= req.span;
				end
			end
			D_PREP: begin
				rem_q <= num[DEPTH_W+GRAY_W-1:GRAY_W];
				low_q <= num[GRAY_W-1:0];
			end
			D_RUN: begin
				rem_q <= fits ? DEPTH_W'(trial - {1'b0, span_q}) : trial[DEPTH_W-1:0];
				low_q <= {low_q[GRAY_W-2:0], fits};
			end
			default: ;
		endcase
	end

	assign rsp.done = done_q;
	assign rsp.quot = low_q;

endmodule

>>> src/depth_min_max_normalizer.sv
// Channel  | direction | handshake               | payload
// item     | in        | item_valid / item_stall  | item   (op, col, row, depth)
// result   | out       | result_valid / result_stall | result (gray, processed, raw_depth)
// cfg      | in        | cfg_valid / cfg_ready    | cfg_index, cfg_data
//
// Start-frame and write transactions may follow back to back.
// A read passes a lookup state and an output state when no division is needed (raw,
// saturated or unprocessed pixel) and the 16-step quotient loop of the divider otherwise.
// The depth store is a single-port-write, registered-read RAM with no reset: reading
// a pixel never written returns whatever the RAM holds.
// Reset clears the control state, the running range and the registers.
// A stalled result holds in the output register; no item is accepted while a read is in
// flight, and a read's result waits until the slot is free of one still waiting.
module depth_min_max_normalizer (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        item_valid,
	output logic                        item_stall,
	input  dmmn_pkg::item_t             item,
	output logic                        result_valid,
	input  logic                        result_stall,
	output dmmn_pkg::result_t           result,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [dmmn_pkg::REG_W-1:0]  cfg_index,
	input  logic [dmmn_pkg::DEPTH_W-1:0] cfg_data
);

	import dmmn_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_LOOK = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	// configuration
	logic               auto_q;
	logic               invert_q;
	logic [DEPTH_W-1:0] manual_min_q;
	logic [DEPTH_W-1:0] manual_max_q;
	logic [COORD_W-1:0] left_q;
	logic [COORD_W-1:0] right_q;
	logic [COORD_W-1:0] bottom_q;
	logic [COORD_W-1:0] top_q;

	// running range of the current frame
	logic [DEPTH_W-1:0] run_min_q;
	logic [DEPTH_W-1:0] run_max_q;

	logic [1:0]         state_q;
	logic               item_acc;
	logic               in_frame;
	logic [ADDR_W-1:0]  addr;
	logic               wr_en;
	logic               rd_en;
	logic [DEPTH_W-1:0] rd_data;

	// read in flight
	logic [COORD_W-1:0] col_s1;
	logic [COORD_W-1:0] row_s1;
	logic               in_frame_s1;
	logic [DEPTH_W-1:0] raw_q;
	logic               proc_q;
	logic [GRAY_W-1:0]  gray_q;

	logic [DEPTH_W-1:0] raw;
	logic               in_region;
	logic               proc;
	logic [DEPTH_W-1:0] lo;
	logic [DEPTH_W-1:0] hi;

	div_req_t           div_req;
	div_rsp_t           div_rsp;

	logic               res_valid_q;
	result_t            res_q;
	logic               res_free;

	assign cfg_ready  = 1'b1;
	assign item_stall = (state_q != S_IDLE);
	assign item_acc   = item_valid && !item_stall;

	assign in_frame = (int'(item.col) < MAX_WIDTH) && (int'(item.row) < MAX_HEIGHT);
	assign addr     = ADDR_W'(int'(item.row) * MAX_WIDTH + int'(item.col));
	assign wr_en    = item_acc && (item.op == OP_WRITE) && in_frame;
	assign rd_en    = item_acc && (item.op == OP_READ);

	dmmn_ram #(
		.WIDTH(DEPTH_W),
		.DEPTH(STORE_SIZE)
	) u_store (
		.clk  (clk),
		.we   (wr_en),
		.waddr(addr),
		.wdata(item.depth),
		.re   (rd_en),
		.raddr(addr),
		.rdata(rd_data)
	);

	// Configuration writes land at once; issue them only while no transaction is in flight.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			auto_q       <= 1'b0;
			invert_q     <= 1'b0;
			manual_min_q <= '0;
			manual_max_q <= '0;
			left_q       <= '0;
			right_q      <= '0;
			bottom_q     <= '0;
			top_q        <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_AUTO_NORMALISE: auto_q       <= cfg_data[0];
				REG_INVERT_OUTPUT:  invert_q     <= cfg_data[0];
				REG_MANUAL_MIN:     manual_min_q <= cfg_data;
				REG_MANUAL_MAX:     manual_max_q <= cfg_data;
				REG_REGION_LEFT:    left_q       <= cfg_data[COORD_W-1:0];
				REG_REGION_RIGHT:   right_q      <= cfg_data[COORD_W-1:0];
				REG_REGION_BOTTOM:  bottom_q     <= cfg_data[COORD_W-1:0];
				REG_REGION_TOP:     top_q        <= cfg_data[COORD_W-1:0];
				default: ;
			endcase
		end
	end

	// Reset the range at frame start; widen it with every valid write, overwrites included.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_min_q <= DEPTH_MAX;
			run_max_q <= '0;
		end else if (item_acc && (item.op == OP_START)) begin
			run_min_q <= DEPTH_MAX;
			run_max_q <= '0;
		end else if (wr_en && (item.depth != '0)) begin
			if (item.depth < run_min_q) begin
				run_min_q <= item.depth;
			end
			if (item.depth > run_max_q) begin
				run_max_q <= item.depth;
			end
		end
	end

	// Pixel classification in the cycle after the read is issued.
	assign raw       = in_frame_s1 ? rd_data : '0;
	assign in_region = (col_s1 >= left_q) && (col_s1 <= right_q) &&
	                   (row_s1 >= bottom_q) && (row_s1 <= top_q);
	assign proc      = (raw != '0) && in_region;
	assign lo        = auto_q ? run_min_q : manual_min_q;
	assign hi        = auto_q ? run_max_q : manual_max_q;

	// Divide only when lo < raw < hi; the quotient then stays below one.
	assign div_req.start = (state_q == S_LOOK) && proc && (raw < hi) && (raw > lo);
	assign div_req.diff  = raw - lo;
	assign div_req.span  = hi - lo;

	dmmn_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	assign res_free = !res_valid_q || !result_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (rd_en) begin
						state_q <= S_LOOK;
					end
				end
				S_LOOK: state_q <= div_req.start ? S_DIV : S_OUT;
				S_DIV: begin
					if (div_rsp.done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Capture the read address side and then the pixel's grey before inversion.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			col_s1      <= item.col;
			row_s1      <= item.row;
			in_frame_s1 <= in_frame;
		end
		if (state_q == S_LOOK) begin
			raw_q  <= raw;
			proc_q <= proc;
			if (proc && (raw >= hi)) begin
				gray_q <= GRAY_ONE;
			end else begin
				gray_q <= '0;
			end
		end
		if ((state_q == S_DIV) && div_rsp.done) begin
			gray_q <= div_rsp.quot;
		end
	end

	// Hold a stalled result; load the next one once the slot drains.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((state_q == S_OUT) && res_free) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if ((state_q == S_OUT) && res_free) begin
			res_q.gray      <= (proc_q && invert_q) ? GRAY_ONE - gray_q : gray_q;
			res_q.processed <= proc_q;
			res_q.raw_depth <= raw_q;
		end
	end

	assign result_valid = res_valid_q;
	assign result       = res_q;

endmodule

>>> test/depth_min_max_normalizer_test.sv
module depth_min_max_normalizer_test;
	timeunit 1ns;
	timeprecision 1ps;

	import dmmn_pkg::*;

	// Op code 3 has no meaning; the block must swallow it without a result.
	localparam logic [OP_W-1:0] OP_IGNORED = 2'd3;

	// Leave room for a read that needs the divider; allow a margin on top.
	localparam int SETTLE_CYCLES = 32;
	// The slowest correct run is far below this: about 1800 transactions, each at
	// most a long sender gap, a full division and a long receiver stall.
	localparam int CYCLE_LIMIT = 1_000_000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic item_valid = 1'b0;
	logic item_stall;
	item_t item = '0;

	logic result_valid;
	logic result_stall = 1'b0;
	result_t result;

	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [REG_W-1:0] cfg_index = '0;
	logic [DEPTH_W-1:0] cfg_data = '0;

	// Shadow of the configuration registers.
	logic auto_mode = 1'b0;
	logic invert_mode = 1'b0;
	logic [DEPTH_W-1:0] fixed_lo = '0;
	logic [DEPTH_W-1:0] fixed_hi = '0;
	logic [COORD_W-1:0] win_left = '0;
	logic [COORD_W-1:0] win_right = '0;
	logic [COORD_W-1:0] win_bottom = '0;
	logic [COORD_W-1:0] win_top = '0;

	// Shadow of the frame store and of the running depth range.
	logic [DEPTH_W-1:0] frame_depth [STORE_SIZE];
	bit pixel_written [STORE_SIZE];
	logic [ADDR_W-1:0] written_pixels [$];
	logic [DEPTH_W-1:0] run_lo = DEPTH_MAX;
	logic [DEPTH_W-1:0] run_hi = '0;

	result_t expected_pixels [$];
	result_t want;

	bit gaps_on = 1'b1;
	bit stalls_on = 1'b1;
	int stall_left = 0;
	int mismatches = 0;
	int cycle_count = 0;

	depth_min_max_normalizer u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.item_valid   (item_valid),
		.item_stall   (item_stall),
		.item         (item),
		.result_valid (result_valid),
		.result_stall (result_stall),
		.result       (result),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always #2 clk = ~clk;

	// Watchdog: a hung handshake ends the run here.
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	task automatic log_mismatch(input string msg);
		$display("%0t: mismatch: %s", $time, msg);
		mismatches++;
	endtask

	// Mostly no gap, often a short one, now and then a long one.
	function automatic int pick_idle();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		if (r < 98)
			return $urandom_range(4, 12);
		return $urandom_range(20, 40);
	endfunction

	// Q0.16 grey of depth v within lo..hi; the top check wins over the bottom one,
	// so a value at or above hi saturates to one even in an empty or reversed range.
	function automatic logic [GRAY_W-1:0] scale_to_grey(input logic [DEPTH_W-1:0] v,
			input logic [DEPTH_W-1:0] lo, input logic [DEPTH_W-1:0] hi);
		logic [47:0] num;
		if (v >= hi)
			return GRAY_ONE;
		if (v <= lo)
			return '0;
		num = 48'(v - lo) * 48'(GRAY_ONE);
		return GRAY_W'(num / 48'(hi - lo));
	endfunction

	// Advance the shadow state by one accepted transaction and queue the pixel that a
	// read is due to return.
	function automatic void predict_item(input item_t it);
		logic [ADDR_W-1:0] addr;
		logic [DEPTH_W-1:0] lo;
		logic [DEPTH_W-1:0] hi;
		result_t px;
		addr = {it.row, it.col};
		case (it.op)
		OP_START: begin
			run_lo = DEPTH_MAX;
			run_hi = '0;
		end
		OP_WRITE: begin
			if (!pixel_written[addr]) begin
				pixel_written[addr] = 1'b1;
				written_pixels.push_back(addr);
			end
			frame_depth[addr] = it.depth;
			// Zero marks an invalid sample; it is stored but leaves the range alone.
			if (it.depth != '0) begin
				if (it.depth < run_lo)
					run_lo = it.depth;
				if (it.depth > run_hi)
					run_hi = it.depth;
			end
		end
		OP_READ: begin
			px.raw_depth = frame_depth[addr];
			px.gray = '0;
			px.processed = 1'b0;
			if (px.raw_depth != '0 && it.col >= win_left && it.col <= win_right &&
					it.row >= win_bottom && it.row <= win_top) begin
				lo = auto_mode ? run_lo : fixed_lo;
				hi = auto_mode ? run_hi : fixed_hi;
				px.gray = scale_to_grey(px.raw_depth, lo, hi);
				if (invert_mode)
					px.gray = GRAY_ONE - px.gray;
				px.processed = 1'b1;
			end
			expected_pixels.push_back(px);
		end
		default: ;
		endcase
	endfunction

	// Send one transaction. Valid stays high on return so that a following call with
	// no gap keeps the channel busy; settle_block drops it.
	task automatic send_item(input item_t it);
		int gap;
		gap = gaps_on ? pick_idle() : 0;
		if (gap != 0) begin
			item_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_valid <= 1'b1;
		item <= it;
		do @(posedge clk); while (item_stall);
		predict_item(it);
	endtask

	task automatic send_op(input logic [OP_W-1:0] op, input int col, input int row,
			input logic [DEPTH_W-1:0] depth);
		item_t it;
		it.op = op;
		it.col = COORD_W'(col);
		it.row = COORD_W'(row);
		it.depth = depth;
		send_item(it);
	endtask

	// Write one register; valid is left high for a back-to-back write.
	task automatic write_reg(input logic [REG_W-1:0] idx, input logic [DEPTH_W-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		case (idx)
		REG_AUTO_NORMALISE: auto_mode = value[0];
		REG_INVERT_OUTPUT:  invert_mode = value[0];
		REG_MANUAL_MIN:     fixed_lo = value;
		REG_MANUAL_MAX:     fixed_hi = value;
		REG_REGION_LEFT:    win_left = value[COORD_W-1:0];
		REG_REGION_RIGHT:   win_right = value[COORD_W-1:0];
		REG_REGION_BOTTOM:  win_bottom = value[COORD_W-1:0];
		REG_REGION_TOP:     win_top = value[COORD_W-1:0];
		default: ;
		endcase
	endtask

	// Program every register. The narrow ones carry random upper bits, which the
	// block must drop.
	task automatic program_regs(input bit use_auto, input bit inv,
			input logic [DEPTH_W-1:0] lo, input logic [DEPTH_W-1:0] hi,
			input int l, input int r, input int b, input int t);
		write_reg(REG_AUTO_NORMALISE, {23'($urandom), use_auto});
		write_reg(REG_INVERT_OUTPUT, {23'($urandom), inv});
		write_reg(REG_MANUAL_MIN, lo);
		write_reg(REG_MANUAL_MAX, hi);
		write_reg(REG_REGION_LEFT, {16'($urandom), 8'(l)});
		write_reg(REG_REGION_RIGHT, {16'($urandom), 8'(r)});
		write_reg(REG_REGION_BOTTOM, {16'($urandom), 8'(b)});
		write_reg(REG_REGION_TOP, {16'($urandom), 8'(t)});
		cfg_valid <= 1'b0;
	endtask

	// Drop valid, wait for every pending pixel, then let a read in flight finish.
	task automatic settle_block();
		item_valid <= 1'b0;
		while (expected_pixels.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Coordinate around a window edge pair, a little outside it on both sides.
	function automatic logic [COORD_W-1:0] near_window(input logic [COORD_W-1:0] a,
			input logic [COORD_W-1:0] b);
		int lo;
		int hi;
		lo = ((a < b) ? int'(a) : int'(b)) - 2;
		hi = ((a < b) ? int'(b) : int'(a)) + 2;
		if (lo < 0)
			lo = 0;
		if (hi > 255)
			hi = 255;
		return COORD_W'($urandom_range(lo, hi));
	endfunction

	// Depths cluster near the configured bounds and in a dense band, so that the
	// ratio path is hit often, with zeros and full-scale values mixed in.
	function automatic logic [DEPTH_W-1:0] pick_depth();
		int r;
		r = $urandom_range(0, 99);
		if (r < 8)
			return '0;
		if (r < 14)
			return DEPTH_MAX;
		if (r < 22)
			return DEPTH_W'($urandom_range(1, 300));
		if (r < 40)
			return fixed_lo + DEPTH_W'($urandom_range(0, 600)) - DEPTH_W'(300);
		if (r < 58)
			return fixed_hi + DEPTH_W'($urandom_range(0, 600)) - DEPTH_W'(300);
		if (r < 80)
			return DEPTH_W'(24'h000800 + $urandom_range(0, 24'h00F000));
		return DEPTH_W'($urandom);
	endfunction

	// Frames of writes and reads with random content. Reads only ever target a pixel
	// already written, mostly a recent one so the current frame's range applies.
	task automatic run_traffic(input int count);
		int sent;
		int r;
		int n;
		int pick;
		item_t it;
		sent = 0;
		while (sent < count) begin
			it.col = COORD_W'($urandom);
			it.row = COORD_W'($urandom);
			it.depth = DEPTH_W'($urandom);
			r = $urandom_range(0, 99);
			if (r < 3) begin
				it.op = OP_START;
			end else if (r < 5) begin
				it.op = OP_IGNORED;
			end else if (r < 50 || written_pixels.size() == 0) begin
				it.op = OP_WRITE;
				if ($urandom_range(0, 9) < 7) begin
					it.col = near_window(win_left, win_right);
					it.row = near_window(win_bottom, win_top);
				end
				it.depth = pick_depth();
			end else begin
				it.op = OP_READ;
				n = written_pixels.size();
				if (n > 64 && $urandom_range(0, 1) == 1)
					pick = $urandom_range(n - 64, n - 1);
				else
					pick = $urandom_range(0, n - 1);
				{it.row, it.col} = written_pixels[pick];
			end
			send_item(it);
			if (it.op != OP_IGNORED)
				sent++;
		end
	endtask

	// Result side: check each transaction against the oldest pending pixel, then pick
	// the stall for the next cycle.
	always @(posedge clk) begin
		if (arst_n && result_valid && !result_stall) begin
			if (expected_pixels.size() == 0) begin
				log_mismatch($sformatf("result %h with no read pending", result));
			end else begin
				want = expected_pixels.pop_front();
				if (result.gray !== want.gray)
					log_mismatch($sformatf("gray %h, expected %h (raw %h)",
						result.gray, want.gray, want.raw_depth));
				if (result.processed !== want.processed)
					log_mismatch($sformatf("processed %b, expected %b (raw %h)",
						result.processed, want.processed, want.raw_depth));
				if (result.raw_depth !== want.raw_depth)
					log_mismatch($sformatf("raw_depth %h, expected %h",
						result.raw_depth, want.raw_depth));
			end
		end
		if (!stalls_on) begin
			result_stall <= 1'b0;
		end else if (stall_left > 0) begin
			result_stall <= 1'b1;
			stall_left--;
		end else begin
			result_stall <= 1'b0;
			stall_left = pick_idle();
		end
	end

	// Fixed range with full region: saturation at both ends, a pixel on each bound,
	// an invalid zero sample, the far corners of the frame and an ignored op.
	task automatic test_manual_range();
		program_regs(1'b0, 1'b0, 24'h000100, 24'h010000, 0, 255, 0, 255);
		send_op(OP_WRITE, 0, 0, DEPTH_MAX);
		send_op(OP_WRITE, 255, 255, 24'h000001);
		send_op(OP_WRITE, 255, 0, 24'h008880);
		send_op(OP_WRITE, 0, 255, 24'h000100);
		send_op(OP_WRITE, 128, 128, 24'h000000);
		send_op(OP_WRITE, 1, 1, 24'h010000);
		send_op(OP_IGNORED, 255, 255, DEPTH_MAX);
		send_op(OP_READ, 0, 0, 24'h000000);
		send_op(OP_READ, 255, 255, DEPTH_MAX);
		send_op(OP_READ, 255, 0, 24'h000000);
		send_op(OP_READ, 0, 255, 24'h000000);
		send_op(OP_READ, 128, 128, 24'h000000);
		send_op(OP_READ, 1, 1, 24'h000000);
		settle_block();
	endtask

	// Running range, inverted, small region: a read before any valid write in the
	// frame (empty range), overwritten pixels that still widen the range, and a
	// pixel just outside the region.
	task automatic test_auto_range_inverted();
		program_regs(1'b1, 1'b1, DEPTH_MAX, 24'h000000, 100, 200, 50, 60);
		send_op(OP_WRITE, 100, 50, 24'h002000);
		send_op(OP_START, 0, 0, 24'h000000);
		send_op(OP_READ, 100, 50, 24'h000000);
		send_op(OP_WRITE, 200, 60, 24'h000800);
		send_op(OP_WRITE, 100, 50, 24'h003000);
		send_op(OP_WRITE, 150, 55, 24'h001000);
		send_op(OP_WRITE, 150, 55, 24'h000400);
		send_op(OP_WRITE, 99, 50, 24'h001800);
		send_op(OP_READ, 150, 55, 24'h000000);
		send_op(OP_READ, 200, 60, 24'h000000);
		send_op(OP_READ, 100, 50, 24'h000000);
		send_op(OP_READ, 99, 50, 24'h000000);
		settle_block();
	endtask

	// Left past right: nothing is processed, raw depth still comes back.
	task automatic test_empty_region();
		program_regs(1'b0, 1'b0, 24'h000000, DEPTH_MAX, 10, 9, 0, 255);
		send_op(OP_READ, 255, 255, 24'h000000);
		send_op(OP_READ, 0, 0, 24'h000000);
		settle_block();
	endtask

	task automatic test_random_manual();
		logic [DEPTH_W-1:0] lo;
		lo = DEPTH_W'($urandom_range(0, 24'h7FFFFF));
		program_regs(1'b0, 1'b0, lo, lo + DEPTH_W'($urandom_range(1, 24'h7FFFFF)),
			0, 255, 0, 255);
		run_traffic(400);
		settle_block();
	endtask

	task automatic test_random_auto();
		int l;
		int b;
		l = $urandom_range(0, 200);
		b = $urandom_range(0, 200);
		program_regs(1'b1, 1'b0, DEPTH_W'($urandom), DEPTH_W'($urandom),
			l, $urandom_range(l, 255), b, $urandom_range(b, 255));
		run_traffic(400);
		settle_block();
	endtask

	// Back-to-back traffic on both sides, no idling at all.
	task automatic test_random_auto_no_idle();
		gaps_on = 1'b0;
		stalls_on = 1'b0;
		program_regs(1'b1, 1'b1, 24'h000000, 24'h000000, 0, 255, 0, 255);
		run_traffic(300);
		settle_block();
		gaps_on = 1'b1;
		stalls_on = 1'b1;
	endtask

	// Equal bounds: every processed pixel saturates one way or the other.
	task automatic test_random_flat_range();
		logic [DEPTH_W-1:0] lo;
		lo = DEPTH_W'($urandom_range(24'h000800, 24'h010000));
		program_regs(1'b0, 1'b1, lo, lo, $urandom_range(0, 50), $urandom_range(200, 255),
			$urandom_range(0, 50), $urandom_range(200, 255));
		run_traffic(200);
		settle_block();
	endtask

	// Minimum above maximum: the top bound is checked first.
	task automatic test_random_reversed_range();
		program_regs(1'b0, 1'b0, 24'h00C000, 24'h002000, 0, 255, 0, 255);
		run_traffic(150);
		settle_block();
	endtask

	// Widest possible range with full-scale region edges.
	task automatic test_random_wide_range();
		stalls_on = 1'b1;
		program_regs(1'b0, 1'b1, 24'h000000, DEPTH_MAX, 0, 255, 0, 255);
		run_traffic(250);
		settle_block();
	endtask

	// Bottom past top in auto mode: again nothing is processed.
	task automatic test_random_empty_rows();
		program_regs(1'b1, 1'b0, DEPTH_MAX, DEPTH_MAX, 0, 255, 255, 0);
		run_traffic(100);
		settle_block();
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		test_manual_range();
		test_auto_range_inverted();
		test_empty_region();
		test_random_manual();
		test_random_auto();
		test_random_auto_no_idle();
		test_random_flat_range();
		test_random_reversed_range();
		test_random_wide_range();
		test_random_empty_rows();
		if (mismatches == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule
